@@ rtl/core/source_azimuth_elevation_distance_unit_assert.svh @@
// Assertion macros for the azimuth / elevation / distance unit.
// The enclosing module provides clk and rst_n.
`ifndef SOURCE_AZIMUTH_ELEVATION_DISTANCE_UNIT_ASSERT_SVH
`define SOURCE_AZIMUTH_ELEVATION_DISTANCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SAED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("saed assertion failed");
`define SAED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("saed assertion failed");
`else
`define SAED_ASSERT_NOW(lbl, ante, cons)
`define SAED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/core/saed_pkg.sv @@
package saed_pkg;

  localparam int COORD_W  = 32;
  localparam int COEF_W   = 32;
  localparam int NUM_COEF = 8;
  localparam int IDX_W    = 3;
  localparam int AZ_W     = 15;
  localparam int EL_W     = 14;
  localparam int DIST_W   = 32;

  localparam logic [IDX_W-1:0] REG_XROW_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_XROW_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_XROW_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_XROW_W = 3'd3;
  localparam logic [IDX_W-1:0] REG_ZROW_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_ZROW_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_ZROW_Z = 3'd6;
  localparam logic [IDX_W-1:0] REG_ZROW_W = 3'd7;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sd65536;

  localparam int DEF_ANGLE_FRAC_BITS = 6;

  localparam int CORDIC_STEPS = 28;
  localparam int ACC_FRAC     = 24;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 5;
  localparam int SQRT_STEPS   = 32;
  localparam int SQRT_LAT     = SQRT_STEPS + 1;

  // atan(2^-i) in 2^-24 degree
  localparam logic [30:0] ATAN_TAB [CORDIC_STEPS] = '{
    31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938, 31'd60000934,
    31'd30029717, 31'd15018523, 31'd7509720, 31'd3754917, 31'd1877466,
    31'd938734, 31'd469367, 31'd234684, 31'd117342, 31'd58671, 31'd29335,
    31'd14668, 31'd7334, 31'd3667, 31'd1833, 31'd917, 31'd458, 31'd229,
    31'd115, 31'd57, 31'd29, 31'd14, 31'd7
  };

  typedef struct packed {
    logic y_zero;
    logic x_zero;
    logic y_neg;
    logic x_neg;
  } quad_t;

  function automatic logic [5:0] msb_pos(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

@@ rtl/core/saed_in_if.sv @@
interface saed_in_if import saed_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] src_x;
  logic signed [COORD_W-1:0] src_y;
  logic signed [COORD_W-1:0] src_z;
  logic signed [COORD_W-1:0] src_w;
  logic signed [COORD_W-1:0] cam_x;
  logic signed [COORD_W-1:0] cam_y;
  logic signed [COORD_W-1:0] cam_z;

  modport source (output valid, src_x, src_y, src_z, src_w, cam_x, cam_y, cam_z,
                  input ready);
  modport sink (input valid, src_x, src_y, src_z, src_w, cam_x, cam_y, cam_z,
                output ready);
endinterface

@@ rtl/core/saed_out_if.sv @@
interface saed_out_if import saed_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [AZ_W-1:0] azimuth_out;
  logic signed [EL_W-1:0] elevation_out;
  logic [DIST_W-1:0]      distance_out;
  logic                   coincident;

  modport source (output valid, azimuth_out, elevation_out, distance_out, coincident,
                  input ready);
  modport sink (input valid, azimuth_out, elevation_out, distance_out, coincident,
                output ready);
endinterface

@@ rtl/core/source_azimuth_elevation_distance_unit.sv @@
// Sound source azimuth / elevation / distance unit.
// Throughput: one beat per cycle; an output stall freezes the whole pipeline.
// Longest path: a 33-stage square root and a 33-stage CORDIC in series for elevation.
// Reset (synchronous, rst_n low): clears all valid bits, coefficients go to identity rows.
`include "source_azimuth_elevation_distance_unit_assert.svh"

module source_azimuth_elevation_distance_unit import saed_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  saed_in_if.sink           in_ch,
  saed_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  localparam int ANG_W     = ANGLE_FRAC_BITS + 9;
  localparam int NORM_W    = 31;
  localparam int AZ_IN     = 4;
  localparam int DIST_IN   = 3;
  localparam int ELSQ_IN   = 6;
  localparam int EL_H      = ELSQ_IN + SQRT_LAT;
  localparam int EL_DONE   = EL_H + CORDIC_LAT;
  localparam int TOTAL     = EL_DONE + 1;
  localparam int AZ_DLY    = EL_DONE - (AZ_IN + CORDIC_LAT);
  localparam int DIST_DLY  = EL_DONE - (DIST_IN + SQRT_LAT);
  localparam int UY_DLY    = EL_H - AZ_IN;
  localparam int COIN_DLY  = EL_DONE - AZ_IN;

  logic             en;
  logic [TOTAL-1:0] vld_r;

  logic signed [COEF_W-1:0] coef_r [NUM_COEF];

  // stage 1
  logic signed [COORD_W-1:0] src [4];
  logic signed [32:0] dx, dy, dz;
  logic signed [63:0] p1_r [NUM_COEF];
  logic [32:0] ux1_r, uy1_r, uz1_r;
  logic        dyneg1_r;

  // stage 2
  logic signed [63:0] sxa2_r, sxb2_r, sza2_r, szb2_r;
  logic [63:0] a2_r, b2_r, c2_r;
  logic [32:0] m2, ux2_r, uy2_r, uz2_r, m2_r;
  logic        dyneg2_r, coin2_r;

  // stage 3
  logic signed [63:0] csx3_r, csz3_r;
  logic [64:0] s_sum, t_sum;
  logic [63:0] t3_r;
  logic        ovf3_r;
  logic [5:0]  p3_r;
  logic [32:0] ux3_r, uy3_r, uz3_r;
  logic        dyneg3_r, coin3_r;

  // stage 4
  logic [63:0] ya4_r, xa4_r;
  logic        yneg4_r, xneg4_r;
  logic [63:0] uxw, uyw, uzw;
  logic [NORM_W-1:0] ux4_r, uy4_r, uz4_r;
  logic        dyneg4_r, coin4_r;

  // stages 5, 6
  logic [61:0] sqx5_r, sqz5_r;
  logic [62:0] hs6_r;

  // back end
  logic [32:0]             dist_root;
  logic                    ovf_d;
  logic [DIST_W-1:0]       dist_sat, dist_d;
  logic signed [ANG_W-1:0] az_ang, el_ang;
  logic [ANG_W-1:0]        az_d;
  logic [32:0]             h_root;
  logic [NORM_W:0]         uyn_d;
  logic                    coin_d;

  logic signed [AZ_W-1:0] az_o_r;
  logic signed [EL_W-1:0] el_o_r;
  logic [DIST_W-1:0]      dist_o_r;
  logic                   coin_o_r;

  assign en          = !vld_r[TOTAL-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (IDX_W'(i) == REG_XROW_X || IDX_W'(i) == REG_ZROW_Z) ? COEF_ONE : '0;
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  // stage 1: view products, world deltas
  assign src[0] = in_ch.src_x;
  assign src[1] = in_ch.src_y;
  assign src[2] = in_ch.src_z;
  assign src[3] = in_ch.src_w;

  assign dx = 33'(in_ch.cam_x) - 33'(in_ch.src_x);
  assign dy = 33'(in_ch.cam_y) - 33'(in_ch.src_y);
  assign dz = 33'(in_ch.cam_z) - 33'(in_ch.src_z);

  for (genvar g = 0; g < 4; g++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[g]     <= coef_r[g] * src[g];
        p1_r[g + 4] <= coef_r[g + 4] * src[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r    <= dx[32] ? 33'(-dx) : dx;
      uy1_r    <= dy[32] ? 33'(-dy) : dy;
      uz1_r    <= dz[32] ? 33'(-dz) : dz;
      dyneg1_r <= dy[32];
    end
  end

  // stage 2
  always_comb begin
    m2 = (ux1_r > uy1_r) ? ux1_r : uy1_r;
    if (uz1_r > m2) m2 = uz1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sxa2_r   <= (p1_r[0] >>> 2) + (p1_r[1] >>> 2);
      sxb2_r   <= (p1_r[2] >>> 2) + (p1_r[3] >>> 2);
      sza2_r   <= (p1_r[4] >>> 2) + (p1_r[5] >>> 2);
      szb2_r   <= (p1_r[6] >>> 2) + (p1_r[7] >>> 2);
      a2_r     <= ux1_r * ux1_r;
      b2_r     <= uy1_r * uy1_r;
      c2_r     <= uz1_r * uz1_r;
      m2_r     <= m2;
      ux2_r    <= ux1_r;
      uy2_r    <= uy1_r;
      uz2_r    <= uz1_r;
      dyneg2_r <= dyneg1_r;
      coin2_r  <= (m2 == '0);
    end
  end

  // stage 3
  assign s_sum = {1'b0, a2_r} + {1'b0, b2_r};
  assign t_sum = {1'b0, s_sum[63:0]} + {1'b0, c2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      csx3_r   <= sxa2_r + sxb2_r;
      csz3_r   <= sza2_r + szb2_r;
      t3_r     <= t_sum[63:0];
      ovf3_r   <= s_sum[64] | t_sum[64];
      p3_r     <= msb_pos(64'(m2_r));
      ux3_r    <= ux2_r;
      uy3_r    <= uy2_r;
      uz3_r    <= uz2_r;
      dyneg3_r <= dyneg2_r;
      coin3_r  <= coin2_r;
    end
  end

  // stage 4: magnitudes; largest delta lands in [2^30, 2^31)
  always_comb begin
    if (p3_r > 6'd30) begin
      uxw = 64'(ux3_r) >> (p3_r - 6'd30);
      uyw = 64'(uy3_r) >> (p3_r - 6'd30);
      uzw = 64'(uz3_r) >> (p3_r - 6'd30);
    end else begin
      uxw = 64'(ux3_r) << (6'd30 - p3_r);
      uyw = 64'(uy3_r) << (6'd30 - p3_r);
      uzw = 64'(uz3_r) << (6'd30 - p3_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ya4_r    <= csx3_r[63] ? 64'(-csx3_r) : 64'(csx3_r);
      yneg4_r  <= csx3_r[63];
      xa4_r    <= csz3_r[63] ? 64'(-csz3_r) : 64'(csz3_r);
      xneg4_r  <= csz3_r[63];
      ux4_r    <= uxw[NORM_W-1:0];
      uy4_r    <= uyw[NORM_W-1:0];
      uz4_r    <= uzw[NORM_W-1:0];
      dyneg4_r <= dyneg3_r;
      coin4_r  <= coin3_r;
    end
  end

  // stages 5, 6: horizontal distance squared
  always_ff @(posedge clk) begin
    if (en) begin
      sqx5_r <= ux4_r * ux4_r;
      sqz5_r <= uz4_r * uz4_r;
      hs6_r  <= sqx5_r + sqz5_r;
    end
  end

  // distance
  saed_sqrt u_dist_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (t3_r),
    .root (dist_root)
  );

  saed_delay #(.W(1), .DEPTH(SQRT_LAT)) u_ovf_dly (
    .clk (clk),
    .en  (en),
    .d   (ovf3_r),
    .q   (ovf_d)
  );

  assign dist_sat = (ovf_d || dist_root[32]) ? '1 : dist_root[DIST_W-1:0];

  saed_delay #(.W(DIST_W), .DEPTH(DIST_DLY)) u_dist_dly (
    .clk (clk),
    .en  (en),
    .d   (dist_sat),
    .q   (dist_d)
  );

  // azimuth
  saed_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_az_cordic (
    .clk   (clk),
    .en    (en),
    .ya    (ya4_r),
    .y_neg (yneg4_r),
    .xa    (xa4_r),
    .x_neg (xneg4_r),
    .angle (az_ang)
  );

  saed_delay #(.W(ANG_W), .DEPTH(AZ_DLY)) u_az_dly (
    .clk (clk),
    .en  (en),
    .d   (az_ang),
    .q   (az_d)
  );

  // elevation
  saed_sqrt u_h_sqrt (
    .clk  (clk),
    .en   (en),
    .v    (64'(hs6_r)),
    .root (h_root)
  );

  saed_delay #(.W(NORM_W + 1), .DEPTH(UY_DLY)) u_uy_dly (
    .clk (clk),
    .en  (en),
    .d   ({dyneg4_r, uy4_r}),
    .q   (uyn_d)
  );

  saed_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_el_cordic (
    .clk   (clk),
    .en    (en),
    .ya    (64'(uyn_d[NORM_W-1:0])),
    .y_neg (uyn_d[NORM_W]),
    .xa    (64'(h_root)),
    .x_neg (1'b0),
    .angle (el_ang)
  );

  saed_delay #(.W(1), .DEPTH(COIN_DLY)) u_coin_dly (
    .clk (clk),
    .en  (en),
    .d   (coin4_r),
    .q   (coin_d)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      az_o_r   <= AZ_W'(32'sd0 - 32'($signed(az_d)));
      el_o_r   <= coin_d ? '0 : EL_W'(32'(el_ang));
      dist_o_r <= dist_d;
      coin_o_r <= coin_d;
    end
  end

  assign out_ch.valid         = vld_r[TOTAL-1];
  assign out_ch.azimuth_out   = az_o_r;
  assign out_ch.elevation_out = el_o_r;
  assign out_ch.distance_out  = dist_o_r;
  assign out_ch.coincident    = coin_o_r;

  `SAED_ASSERT_NOW(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready)
  `SAED_ASSERT_NOW(a_coin_zero, out_ch.valid && out_ch.coincident, out_ch.elevation_out == '0 && out_ch.distance_out == '0)
  `SAED_ASSERT_NEXT(a_valid_enters, in_ch.ready, vld_r[0] == $past(in_ch.valid))

endmodule

@@ rtl/core/saed_delay.sv @@
module saed_delay import saed_pkg::*; #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
    end
  end

  for (genvar g = 1; g < DEPTH; g++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[g] <= sr_r[g-1];
      end
    end
  end

  assign q = sr_r[DEPTH-1];

endmodule

@@ rtl/core/saed_sqrt.sv @@
module saed_sqrt import saed_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v,
  output logic [32:0] root
);

  logic [63:0] rem_r [SQRT_STEPS];
  logic [63:0] res_r [SQRT_STEPS];
  logic [63:0] rem_in [SQRT_STEPS];
  logic [63:0] res_in [SQRT_STEPS];
  logic [32:0] root_r;

  // one result bit per stage, restoring
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [64:0] trial;

    if (g == 0) begin : g_first
      assign rem_in[g] = v;
      assign res_in[g] = '0;
    end else begin : g_next
      assign rem_in[g] = rem_r[g-1];
      assign res_in[g] = res_r[g-1];
    end

    assign trial = {1'b0, res_in[g]} + {1'b0, BIT};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in[g]} >= trial) begin
          rem_r[g] <= rem_in[g] - trial[63:0];
          res_r[g] <= (res_in[g] >> 1) + BIT;
        end else begin
          rem_r[g] <= rem_in[g];
          res_r[g] <= res_in[g] >> 1;
        end
      end
    end
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= 33'(res_r[SQRT_STEPS-1])
              + 33'(rem_r[SQRT_STEPS-1] > res_r[SQRT_STEPS-1]);
    end
  end

  assign root = root_r;

endmodule

@@ rtl/core/saed_cordic.sv @@
module saed_cordic import saed_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [63:0]                       ya,
  input  logic                              y_neg,
  input  logic [63:0]                       xa,
  input  logic                              x_neg,
  output logic signed [ANGLE_FRAC_BITS+8:0] angle
);

  localparam int ANG_W  = ANGLE_FRAC_BITS + 9;
  localparam int DP_W   = 34;
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [DP_W-1:0] RIGHT = DP_W'(64'd90 << ACC_FRAC);
  localparam logic [DP_W-1:0] HALF  = DP_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 << ANGLE_FRAC_BITS);

  logic [63:0] ya0_r, xa0_r, m0_r;
  quad_t       f0_r;
  logic [63:0] ya1_r, xa1_r;
  logic [5:0]  p1_r;
  quad_t       f1_r;
  logic [63:0] ysh, xsh;

  logic signed [DP_W-1:0] x_r [CORDIC_STEPS+1];
  logic signed [DP_W-1:0] y_r [CORDIC_STEPS+1];
  logic signed [DP_W-1:0] z_r [CORDIC_STEPS+1];
  quad_t                  f_r [CORDIC_STEPS+1];

  logic signed [DP_W-1:0]  zf;
  logic [DP_W-1:0]         acc;
  logic [DP_W-1:0]         rnd;
  logic signed [ANG_W-1:0] q1_r;
  quad_t                   fq_r;
  logic signed [ANG_W-1:0] qs;
  logic signed [ANG_W-1:0] angle_r;

  // operand capture, common scale search
  always_ff @(posedge clk) begin
    if (en) begin
      ya0_r       <= ya;
      xa0_r       <= xa;
      m0_r        <= (ya > xa) ? ya : xa;
      f0_r.y_zero <= (ya == '0);
      f0_r.x_zero <= (xa == '0);
      f0_r.y_neg  <= y_neg;
      f0_r.x_neg  <= x_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ya1_r <= ya0_r;
      xa1_r <= xa0_r;
      p1_r  <= msb_pos(m0_r);
      f1_r  <= f0_r;
    end
  end

  // larger operand lands in [2^29, 2^30)
  always_comb begin
    if (p1_r > 6'd29) begin
      ysh = ya1_r >> (p1_r - 6'd29);
      xsh = xa1_r >> (p1_r - 6'd29);
    end else begin
      ysh = ya1_r << (6'd29 - p1_r);
      xsh = xa1_r << (6'd29 - p1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= DP_W'(xsh[29:0]);
      y_r[0] <= DP_W'(ysh[29:0]);
      z_r[0] <= '0;
      f_r[0] <= f1_r;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [DP_W-1:0] xs, ys, da;
    assign xs = x_r[g] >>> g;
    assign ys = y_r[g] >>> g;
    assign da = $signed(DP_W'(ATAN_TAB[g]));

    always_ff @(posedge clk) begin
      if (en) begin
        f_r[g+1] <= f_r[g];
        if (y_r[g] > 0) begin
          x_r[g+1] <= x_r[g] + ys;
          y_r[g+1] <= y_r[g] - xs;
          z_r[g+1] <= z_r[g] + da;
        end else if (y_r[g] < 0) begin
          x_r[g+1] <= x_r[g] - ys;
          y_r[g+1] <= y_r[g] + xs;
          z_r[g+1] <= z_r[g] - da;
        end else begin
          x_r[g+1] <= x_r[g];
          y_r[g+1] <= y_r[g];
          z_r[g+1] <= z_r[g];
        end
      end
    end
  end

  // clamp, special cases, round half up
  assign zf = z_r[CORDIC_STEPS];

  always_comb begin
    if (f_r[CORDIC_STEPS].y_zero) begin
      acc = '0;
    end else if (f_r[CORDIC_STEPS].x_zero) begin
      acc = RIGHT;
    end else if (zf < 0) begin
      acc = '0;
    end else if (zf > $signed(RIGHT)) begin
      acc = RIGHT;
    end else begin
      acc = zf;
    end
    rnd = (acc + HALF) >> RND_SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r <= ANG_W'(rnd);
      fq_r <= f_r[CORDIC_STEPS];
    end
  end

  // quadrant fix
  assign qs = fq_r.x_neg ? (HALF_TURN - q1_r) : q1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= fq_r.y_neg ? -qs : qs;
    end
  end

  assign angle = angle_r;

endmodule

@@ dv/saed_checker.sv @@
`timescale 1ns / 1ps

module saed_checker import saed_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  saed_in_if                in_ch,
  saed_out_if               out_ch,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);

  localparam int AFB = DEF_ANGLE_FRAC_BITS;

  typedef struct packed {
    logic [AZ_W-1:0]   az;
    logic [EL_W-1:0]   el;
    logic [DIST_W-1:0] distance;
    logic              coin;
  } geo_t;

  logic signed [COEF_W-1:0] view_coef [NUM_COEF];
  geo_t                     geo_q [$];

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt_round(logic [63:0] v);
    logic [63:0] rem, res, bt;
    rem = v;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (rem >= res + bt) begin
        rem = rem - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    if (rem > res) res = res + 1;
    return res;
  endfunction

  // first-quadrant atan(ya/xa), 2^-24 degree
  function automatic longint quad_deg(logic [63:0] ya, logic [63:0] xa);
    longint      x, y, z, xs, ys, right;
    logic [63:0] m;
    right = longint'(90) <<< ACC_FRAC;
    if (ya == 0) return 0;
    if (xa == 0) return right;
    m = ya > xa ? ya : xa;
    while (m >= (64'd1 << 30)) begin
      m = m >> 1; ya = ya >> 1; xa = xa >> 1;
    end
    while (m < (64'd1 << 29)) begin
      m = m << 1; ya = ya << 1; xa = xa << 1;
    end
    x = longint'(xa);
    y = longint'(ya);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else if (y < 0) begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > right) z = right;
    return z;
  endfunction

  function automatic longint angle_units(logic [63:0] ya, logic yneg, logic [63:0] xa,
                                         logic xneg);
    longint q;
    q = (quad_deg(ya, xa) + (longint'(1) <<< (ACC_FRAC - AFB - 1))) >>> (ACC_FRAC - AFB);
    if (xneg) q = (longint'(180) <<< AFB) - q;
    if (yneg) q = -q;
    return q;
  endfunction

  function automatic geo_t locate_source();
    geo_t        r;
    longint      src [4];
    longint      cam [3];
    longint      csx, csz, az, el, dx, dy, dz;
    logic [63:0] ux, uy, uz, a, b, c, s, t, dst, m, h;
    logic        ovf;
    src[0] = $signed(in_ch.src_x); src[1] = $signed(in_ch.src_y);
    src[2] = $signed(in_ch.src_z); src[3] = $signed(in_ch.src_w);
    cam[0] = $signed(in_ch.cam_x); cam[1] = $signed(in_ch.cam_y);
    cam[2] = $signed(in_ch.cam_z);
    csx = 0;
    csz = 0;
    for (int i = 0; i < 4; i++) begin
      csx = csx + ((longint'(view_coef[i]) * src[i]) >>> 2);
      csz = csz + ((longint'(view_coef[4+i]) * src[i]) >>> 2);
    end
    az = -angle_units(abs64(csx), csx < 0, abs64(csz), csz < 0);
    dx = cam[0] - src[0];
    dy = cam[1] - src[1];
    dz = cam[2] - src[2];
    ux = abs64(dx); uy = abs64(dy); uz = abs64(dz);
    a = ux * ux; b = uy * uy; c = uz * uz;
    s = a + b;
    ovf = s < a;
    t = s + c;
    if (t < s) ovf = 1'b1;
    if (ovf) begin
      dst = 64'hFFFF_FFFF;
    end else begin
      dst = isqrt_round(t);
      if (dst > 64'hFFFF_FFFF) dst = 64'hFFFF_FFFF;
    end
    m = ux > uy ? ux : uy;
    if (uz > m) m = uz;
    el = 0;
    r.coin = (m == 0);
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin
        m = m >> 1; ux = ux >> 1; uy = uy >> 1; uz = uz >> 1;
      end
      while (m < (64'd1 << 30)) begin
        m = m << 1; ux = ux << 1; uy = uy << 1; uz = uz << 1;
      end
      h = isqrt_round(ux * ux + uz * uz);
      el = angle_units(uy, dy < 0, h, 1'b0);
    end
    r.az = AZ_W'(az);
    r.el = EL_W'(el);
    r.distance = dst[31:0];
    return r;
  endfunction

  task automatic report(string what, longint want, longint got);
    if (errors < 20) $display("mismatch %s: expected %0d got %0d", what, want, got);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    geo_t want;
    if (!rst_n) begin
      foreach (view_coef[i]) view_coef[i] = '0;
      view_coef[REG_XROW_X] = COEF_ONE;
      view_coef[REG_ZROW_Z] = COEF_ONE;
      geo_q.delete();
    end else begin
      if (cfg_we) view_coef[cfg_index] = cfg_data;
      if (out_ch.valid && out_ch.ready) begin
        if (geo_q.size() == 0) begin
          report("unexpected beat", 0, 1);
        end else begin
          want = geo_q.pop_front();
          if (out_ch.azimuth_out !== want.az)
            report("azimuth", $signed(want.az), $signed(out_ch.azimuth_out));
          if (out_ch.elevation_out !== want.el)
            report("elevation", $signed(want.el), $signed(out_ch.elevation_out));
          if (out_ch.distance_out !== want.distance)
            report("distance", want.distance, out_ch.distance_out);
          if (out_ch.coincident !== want.coin)
            report("coincident", want.coin, out_ch.coincident);
        end
      end
      if (in_ch.valid && in_ch.ready) geo_q.push_back(locate_source());
    end
    pending = geo_q.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import saed_pkg::*; ();

  localparam int WATCHDOG = 5000;
  localparam int DRAIN    = 100;
  localparam int HOLD     = 400;

  typedef logic [31:0] word_t;
  typedef word_t src_t [7];

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [COEF_W-1:0] cfg_data;
  int                errors, pending;
  int                n_sent, idle_cnt;
  bit                idle_on, hold_req;

  const logic [IDX_W-1:0] reg_ids [NUM_COEF] = '{REG_XROW_X, REG_XROW_Y, REG_XROW_Z,
      REG_XROW_W, REG_ZROW_X, REG_ZROW_Y, REG_ZROW_Z, REG_ZROW_W};

  saed_in_if  in_ch ();
  saed_out_if out_ch ();

  source_azimuth_elevation_distance_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  saed_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // result side
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD) @(negedge clk);
        out_ch.ready <= 1'b1;
        held = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic word_t span(int bits);
    return word_t'($signed($urandom) >>> (31 - bits));
  endfunction

  function automatic word_t corner();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  function automatic src_t random_source();
    src_t s;
    int   k, bits;
    k = $urandom_range(0, 99);
    bits = $urandom_range(4, 30);
    for (int i = 0; i < 7; i++) s[i] = span(bits);
    s[3] = 32'd65536;
    if (k < 15) begin
      for (int i = 0; i < 7; i++) s[i] = $urandom;
    end else if (k < 25) begin
      for (int i = 0; i < 3; i++) s[4+i] = s[i];
    end else if (k < 35) begin
      for (int i = 0; i < 3; i++) if ($urandom_range(0, 1)) s[4+i] = s[i];
    end else if (k < 42) begin
      for (int i = 0; i < 7; i++) s[i] = corner();
    end else if (k < 47) begin
      s[3] = $urandom;
    end
    return s;
  endfunction

  task automatic send(src_t s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.src_x <= s[0]; in_ch.src_y <= s[1]; in_ch.src_z <= s[2]; in_ch.src_w <= s[3];
    in_ch.cam_x <= s[4]; in_ch.cam_y <= s[5]; in_ch.cam_z <= s[6];
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_view(int mode);
    word_t v;
    for (int i = 0; i < NUM_COEF; i++) begin
      case (mode)
        0: v = span(17);
        1: v = 32'h7FFF_FFFF;
        2: v = 32'h8000_0000;
        3: v = 32'h0;
        4: v = $urandom;
        default: v = (i == REG_XROW_X || i == REG_ZROW_Z) ? COEF_ONE : span(12);
      endcase
      cfg_we <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_data <= v;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    src_t d [$];
    src_t s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.src_x = '0; in_ch.src_y = '0; in_ch.src_z = '0; in_ch.src_w = '0;
    in_ch.cam_x = '0; in_ch.cam_y = '0; in_ch.cam_z = '0;
    n_sent = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    d.push_back('{0, 0, 0, 0, 0, 0, 0});
    d.push_back('{0, 0, 32'd65536, 32'd65536, 0, 0, 0});
    d.push_back('{0, 0, -32'sd65536, 32'd65536, 0, 0, 0});
    d.push_back('{32'd65536, 0, 0, 32'd65536, 0, 0, 0});
    d.push_back('{-32'sd65536, 0, 0, 32'd65536, 0, 0, 0});
    d.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    d.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    d.push_back('{0, 32'd65536, 0, 32'd65536, 0, 0, 0});
    d.push_back('{0, -32'sd65536, 0, 32'd65536, 0, 0, 0});
    d.push_back('{32'd196608, 0, 32'd262144, 32'd65536, 0, 0, 0});
    d.push_back('{0, 0, 0, 32'h8000_0000, 0, 0, 0});
    d.push_back('{32'd123456, -32'sd7, 32'd99, 32'd65536, 32'd123456, -32'sd7, 32'd99});
    d.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0});
    d.push_back('{1, 1, 1, 1, 0, 0, 0});
    d.push_back('{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'd65536, 32'h8000_0000, 0, 0});
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 7; j++) s[j] = $urandom;
      d.push_back(s);
    end
    foreach (d[i]) send(d[i]);
    settle();

    for (int p = 0; p < 6; p++) begin
      load_view(p);
      if (p == 5) idle_on = 1'b0;
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < 125; i++) send(random_source());
      settle();
    end

    repeat (DRAIN) @(posedge clk);
    $display("sent %0d sources over reset, identity-like, saturated, zero and random views,",
             n_sent);
    $display("with coincident, axis-aligned, overflow and long output stall cases");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
